// ===== hw/rtl/frame_bitmap_allocator_defines.svh =====
// Assertion macros used by the frame bitmap allocator top level.
// Expects aclk and aresetn to be visible where the macros are used.
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame_bitmap_allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame_bitmap_allocator: next-cycle check failed");

`endif

// ===== hw/rtl/fba_pkg.sv =====
// Shared constants, types and helper functions for the frame bitmap allocator.
// No dependencies; imported by the controller, datapath, top level and testbench.
`timescale 1ns / 1ps

package fba_pkg;

    // Bitmap geometry.
    localparam int NUM_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int LAST_BITS  = NUM_FRAMES - (WORD_COUNT - 1) * WORD_BITS;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
    typedef logic [FRAME_W-1:0]    frame_t;

    localparam word_idx_t LAST_WORD = WORD_IDX_W'(WORD_COUNT - 1);

    // Result status codes as seen on the output channel.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_DONE    = 2'd0;
    localparam status_t STATUS_NOTHING = 2'd1;
    localparam status_t STATUS_NO_MEM  = 2'd2;

    // Internal result classes chosen by the controller.
    typedef logic [1:0] res_code_t;
    localparam res_code_t RES_ALLOC_OK = 2'd0;
    localparam res_code_t RES_NOTHING  = 2'd1;
    localparam res_code_t RES_NO_MEM   = 2'd2;
    localparam res_code_t RES_FREE_OK  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_req;
        logic      scan_start;
        logic      scan_step;
        logic      free_read;
        logic      wr_alloc;
        logic      wr_free;
        logic      res_load;
        res_code_t res_code;
        logic      out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind_free;
        logic frame_zero;
        logic frame_in_range;
        logic found;
        logic scan_last_full;
        logic out_free;
    } dp_status_t;

    // Bits of the last word that lie beyond the last frame count as used.
    function automatic word_t last_pad_mask();
        word_t m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i >= LAST_BITS) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam word_t LAST_PAD = last_pad_mask();

    // Priority encoder: index of the lowest clear bit.
    function automatic bit_idx_t lowest_zero(word_t w);
        bit_idx_t idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // One-hot decode of a bit index.
    function automatic word_t bit_onehot(bit_idx_t idx);
        return word_t'(1) << idx;
    endfunction

endpackage

// ===== hw/rtl/fba_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; used for the frame bitmap storage.
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== hw/rtl/fba_datapath.sv =====
// Datapath of the frame bitmap allocator: request registers, bitmap RAM with
// per-word valid bits, word scanner, bit update and output register.
// Depends on fba_pkg and fba_ram.
`timescale 1ns / 1ps

module fba_datapath
    import fba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_kind,
    input  frame_t     s_page_frame,
    input  logic       s_is_kernel,
    input  logic       s_is_writable,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output status_t    m_status,
    output frame_t     m_frame_out,
    output logic       m_present,
    output logic       m_rw,
    output logic       m_user
);

    // Request registers.
    logic   req_kind_reg;
    frame_t req_frame_reg;
    logic   req_kernel_reg;
    logic   req_writable_reg;

    // Scan state.
    word_idx_t scan_addr_reg;
    word_idx_t chk_addr_reg;
    logic      chk_pending_reg;

    // Bitmap bookkeeping: a word never written reads as all free.
    logic [WORD_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;

    frame_t    alloc_frame_reg;
    res_code_t res_code_reg;
    logic      m_valid_reg;

    word_idx_t rd_addr;
    word_t     ram_rdata;
    logic      wr_en;
    word_idx_t wr_addr;
    word_t     wr_data;
    word_idx_t req_word;
    bit_idx_t  req_bit;
    word_t     word_q;
    word_t     word_eff;
    bit_idx_t  hit_bit;
    logic      not_full;

    // Capture the request when the controller accepts it.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_kind_reg     <= s_kind;
            req_frame_reg    <= s_page_frame;
            req_kernel_reg   <= s_is_kernel;
            req_writable_reg <= s_is_writable;
        end
    end

    assign req_word = WORD_IDX_W'(req_frame_reg >> BIT_IDX_W);
    assign req_bit  = req_frame_reg[BIT_IDX_W-1:0];

    // Word scanner: one read issued per cycle, checked in the cycle after.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg   <= '0;
            chk_addr_reg    <= '0;
            chk_pending_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            scan_addr_reg   <= '0;
            chk_pending_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_addr_reg   <= scan_addr_reg + 1'b1;
            chk_addr_reg    <= scan_addr_reg;
            chk_pending_reg <= 1'b1;
        end
    end

    assign rd_addr = cmd.free_read ? req_word : scan_addr_reg;

    // Valid bits track which words have been written since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Checked word, with frames beyond the end treated as used.
    assign word_q   = rd_valid_reg ? ram_rdata : '0;
    assign word_eff = word_q | ((chk_addr_reg == LAST_WORD) ? LAST_PAD : '0);
    assign not_full = ~(&word_eff);
    assign hit_bit  = lowest_zero(word_eff);

    // Read-modify-write of one bitmap word.
    assign wr_en   = cmd.wr_alloc | cmd.wr_free;
    assign wr_addr = cmd.wr_alloc ? chk_addr_reg : req_word;
    assign wr_data = cmd.wr_alloc ? (word_q | bit_onehot(hit_bit))
                                  : (word_q & ~bit_onehot(req_bit));

    always_ff @(posedge aclk) begin
        if (cmd.wr_alloc) begin
            alloc_frame_reg <= FRAME_W'({chk_addr_reg, hit_bit});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_code_reg <= cmd.res_code;
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (res_code_reg)
                RES_ALLOC_OK: begin
                    m_status    <= STATUS_DONE;
                    m_frame_out <= alloc_frame_reg;
                    m_present   <= 1'b1;
                    m_rw        <= req_writable_reg;
                    m_user      <= ~req_kernel_reg;
                end
                RES_NOTHING: begin
                    m_status    <= STATUS_NOTHING;
                    m_frame_out <= req_frame_reg;
                    m_present   <= 1'b0;
                    m_rw        <= 1'b0;
                    m_user      <= 1'b0;
                end
                RES_NO_MEM: begin
                    m_status    <= STATUS_NO_MEM;
                    m_frame_out <= '0;
                    m_present   <= 1'b0;
                    m_rw        <= 1'b0;
                    m_user      <= 1'b0;
                end
                RES_FREE_OK: begin
                    m_status    <= STATUS_DONE;
                    m_frame_out <= '0;
                    m_present   <= 1'b0;
                    m_rw        <= 1'b0;
                    m_user      <= 1'b0;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    // Status towards the controller.
    assign status.kind_free      = req_kind_reg;
    assign status.frame_zero     = (req_frame_reg == '0);
    assign status.frame_in_range = ({1'b0, req_frame_reg} < (FRAME_W + 1)'(NUM_FRAMES));
    assign status.found          = chk_pending_reg & not_full;
    assign status.scan_last_full = chk_pending_reg & ~not_full & (chk_addr_reg == LAST_WORD);
    assign status.out_free       = ~m_valid_reg | m_ready;

endmodule

// ===== hw/rtl/fba_ctrl.sv =====
// Controller state machine of the frame bitmap allocator.
// Depends on fba_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module fba_ctrl
    import fba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FREE_RD = 3'd3;
    localparam logic [2:0] S_FREE_WR = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_req = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (!status.kind_free && !status.frame_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_NOTHING;
                    state_next   = S_RESP;
                end else if (!status.kind_free) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else if (status.frame_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_NOTHING;
                    state_next   = S_RESP;
                end else if (!status.frame_in_range) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_FREE_OK;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_FREE_RD;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                priority if (status.found) begin
                    cmd.wr_alloc = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_ALLOC_OK;
                    state_next   = S_RESP;
                end else if (status.scan_last_full) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_NO_MEM;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_FREE_RD: begin
                cmd.free_read = 1'b1;
                state_next    = S_FREE_WR;
            end
            S_FREE_WR: begin
                cmd.wr_free  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_code = RES_FREE_OK;
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: keeps one used bit per physical page frame.
// Input channel s_*: one request per transaction (allocate or free a page's frame).
// Output channel m_*: exactly one result transaction per request, in order.
// An allocate for a page without a frame scans the bitmap one 32-bit word per
// cycle from word 0, skips full words, takes the lowest free frame and marks it.
// The time to a result for an allocate grows with the index of the word found
// (up to 128 words), set by the single read port of the bitmap RAM; an
// allocate that finds no free frame takes the full scan; a free reads and then
// writes its word; a request with nothing to do goes straight to its result.
// One request is handled at a time; s_ready is high only while the controller
// is idle, and a new request may be accepted while the previous result still
// waits in the output register.
// When the receiver stalls, the result is held and the next request waits for
// the output register before its own result is written.
// Reset (aresetn low, synchronous) marks every frame free at once through
// per-word valid bits; no clearing pass is needed.
// Depends on fba_pkg, fba_ctrl, fba_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator
    import fba_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_kind,
    input  frame_t  s_page_frame,
    input  logic    s_is_kernel,
    input  logic    s_is_writable,
    output logic    m_valid,
    input  logic    m_ready,
    output status_t m_status,
    output frame_t  m_frame_out,
    output logic    m_present,
    output logic    m_rw,
    output logic    m_user
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    fba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    fba_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_page_frame  (s_page_frame),
        .s_is_kernel   (s_is_kernel),
        .s_is_writable (s_is_writable),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_out   (m_frame_out),
        .m_present     (m_present),
        .m_rw          (m_rw),
        .m_user        (m_user)
    );

    // Bitmap writes only happen while a request is in flight.
    `FBA_ASSERT_IMP(a_write_while_busy, dp_cmd.wr_alloc || dp_cmd.wr_free, !s_ready)
    // An allocation is only written into a word that has a free frame.
    `FBA_ASSERT_IMP(a_alloc_on_hit, dp_cmd.wr_alloc, dp_status.found)
    // After accepting a request the block is busy.
    `FBA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // Loading a result always presents it on the output channel.
    `FBA_ASSERT_NEXT(a_result_presented, dp_cmd.out_load, m_valid)

endmodule

// ===== test/frame_bitmap_allocator_tb.sv =====
// Self-checking testbench for the frame bitmap allocator: drives allocate and free requests
// and predicts each result from its own copy of the used-frame bitmap.
// Depends on fba_pkg and the frame_bitmap_allocator RTL.
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;
    import fba_pkg::*;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam int   MAX_IDLE   = 18;

    // One expected result transaction.
    typedef struct packed {
        status_t status;
        frame_t  frame;
        logic    present;
        logic    rw;
        logic    user;
    } frame_result_t;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    logic    s_kind;
    frame_t  s_page_frame;
    logic    s_is_kernel;
    logic    s_is_writable;
    logic    m_valid;
    logic    m_ready;
    status_t m_status;
    frame_t  m_frame_out;
    logic    m_present;
    logic    m_rw;
    logic    m_user;

    word_t         frame_used [WORD_COUNT];
    frame_result_t expected_results [$];
    frame_t        held_frames [$];
    int            mismatch_count;
    logic          sender_idles;
    logic          sink_idles;
    int            sink_hold_cycles;

    frame_bitmap_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_page_frame  (s_page_frame),
        .s_is_kernel   (s_is_kernel),
        .s_is_writable (s_is_writable),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_out   (m_frame_out),
        .m_present     (m_present),
        .m_rw          (m_rw),
        .m_user        (m_user)
    );

    // Clock: 10 ns period.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog against a hung block.
    initial begin
        #40_000_000;
        $display("frame_bitmap_allocator_tb: errors");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Works out the result of one request and updates the bitmap copy.
    function automatic frame_result_t predict_frame_result(input logic kind, input frame_t pf,
                                                           input logic kern, input logic wr);
        frame_result_t res;
        logic          found;
        logic          stop;
        int            f;
        int            hit;
        frame_t        hf;
        res = '0;
        found = 1'b0;
        stop = 1'b0;
        hit = 0;
        if (kind == KIND_ALLOC) begin
            if (pf != '0) begin
                res.status = STATUS_NOTHING;
                res.frame = pf;
            end else begin
                // Lowest clear bit of the first word that is not full.
                for (int w = 0; w < WORD_COUNT && !found && !stop; w++) begin
                    if (frame_used[w] != '1) begin
                        for (int b = 0; b < WORD_BITS && !found && !stop; b++) begin
                            f = w * WORD_BITS + b;
                            if (f >= NUM_FRAMES) begin
                                stop = 1'b1;
                            end else if (!frame_used[w][b]) begin
                                found = 1'b1;
                                hit = f;
                            end
                        end
                        stop = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = STATUS_NO_MEM;
                end else begin
                    hf = frame_t'(hit);
                    frame_used[hf[FRAME_W-1:BIT_IDX_W]][hf[BIT_IDX_W-1:0]] = 1'b1;
                    res.status = STATUS_DONE;
                    res.frame = hf;
                    res.present = 1'b1;
                    res.rw = wr;
                    res.user = ~kern;
                end
            end
        end else begin
            if (pf == '0) begin
                res.status = STATUS_NOTHING;
            end else begin
                if (int'(pf) < NUM_FRAMES) begin
                    frame_used[pf[FRAME_W-1:BIT_IDX_W]][pf[BIT_IDX_W-1:0]] = 1'b0;
                end
                res.status = STATUS_DONE;
            end
        end
        return res;
    endfunction

    // Offers one request, after a random gap when sender_idles is set, and records its expected result once accepted.
    task automatic send_request(input logic kind, input frame_t pf, input logic kern,
                                input logic wr, output frame_result_t res);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_page_frame  <= pf;
        s_is_kernel   <= kern;
        s_is_writable <= wr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        res = predict_frame_result(kind, pf, kern, wr);
        expected_results.push_back(res);
        if (kind == KIND_ALLOC && res.status == STATUS_DONE && res.frame != '0) begin
            held_frames.push_back(res.frame);
        end
    endtask

    // Withdraws the request and waits until every outstanding result has been received.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Extremes of the fields and every named special case, from a clear bitmap.
    task automatic test_directed();
        frame_result_t r;
        send_request(KIND_ALLOC, 12'd0, 1'b0, 1'b1, r);    // frame zero is a real frame
        send_request(KIND_ALLOC, 12'd0, 1'b1, 1'b0, r);
        send_request(KIND_ALLOC, 12'd4095, 1'b0, 1'b1, r); // entry already holds a frame
        send_request(KIND_ALLOC, 12'd1, 1'b1, 1'b1, r);
        send_request(KIND_FREE, 12'd0, 1'b1, 1'b1, r);     // no frame held, frame zero kept
        send_request(KIND_FREE, 12'd1, 1'b0, 1'b0, r);
        send_request(KIND_ALLOC, 12'd0, 1'b1, 1'b1, r);    // reuses frame one, not zero
        send_request(KIND_FREE, 12'd4095, 1'b1, 1'b0, r);  // already free
        send_request(KIND_FREE, 12'd2, 1'b0, 1'b1, r);
        send_request(KIND_ALLOC, 12'd0, 1'b0, 1'b0, r);
        send_request(KIND_ALLOC, 12'd0, 1'b1, 1'b1, r);
        send_request(KIND_ALLOC, 12'd0, 1'b0, 1'b1, r);
        send_request(KIND_FREE, 12'd3, 1'b1, 1'b1, r);
        send_request(KIND_ALLOC, 12'd0, 1'b1, 1'b0, r);
        send_request(KIND_FREE, 12'h800, 1'b0, 1'b0, r);
        send_request(KIND_ALLOC, 12'h7FF, 1'b0, 1'b0, r);
        send_request(KIND_FREE, 12'h555, 1'b1, 1'b0, r);
        send_request(KIND_ALLOC, 12'hAAA, 1'b1, 1'b1, r);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        frame_result_t r;
        sender_idles = 1'b0;
        sink_hold_cycles = 400;
        for (int i = 0; i < 10; i++) begin
            send_request(i[0] ? KIND_FREE : KIND_ALLOC, i[0] ? frame_t'(i) : '0,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
        end
        sender_idles = 1'b1;
    endtask

    // Mostly well-formed allocate/free sequences, with some stray requests mixed in.
    task automatic test_random_mix(input int count, input int alloc_pct);
        frame_result_t r;
        int            idx;
        frame_t        f;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 3))
                    0: begin
                        send_request(KIND_ALLOC, frame_t'($urandom_range(1, 4095)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
                    end
                    1: begin
                        send_request(KIND_FREE, '0, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), r);
                    end
                    2: begin
                        send_request(KIND_FREE, frame_t'($urandom_range(0, 4095)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
                    end
                    default: begin
                        send_request(KIND_ALLOC, frame_t'($urandom_range(0, 4095)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
                    end
                endcase
            end else if (held_frames.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
                send_request(KIND_ALLOC, '0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), r);
            end else begin
                idx = $urandom_range(0, held_frames.size() - 1);
                f = held_frames[idx];
                held_frames.delete(idx);
                send_request(KIND_FREE, f, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), r);
            end
        end
    endtask

    // Result sink: random stalls per transaction, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Compares every accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected result, frame_out", int'(m_frame_out), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    note_mismatch("status", int'(m_status), int'(want.status));
                end
                if (m_frame_out !== want.frame) begin
                    note_mismatch("frame_out", int'(m_frame_out), int'(want.frame));
                end
                if (m_present !== want.present) begin
                    note_mismatch("present", int'(m_present), int'(want.present));
                end
                if (m_rw !== want.rw) begin
                    note_mismatch("rw", int'(m_rw), int'(want.rw));
                end
                if (m_user !== want.user) begin
                    note_mismatch("user", int'(m_user), int'(want.user));
                end
            end
        end
    end

    // Test sequence.
    initial begin
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_ALLOC;
        s_page_frame = '0;
        s_is_kernel = 1'b0;
        s_is_writable = 1'b0;
        mismatch_count = 0;
        sender_idles = 1'b1;
        sink_idles = 1'b1;
        sink_hold_cycles = 0;
        for (int w = 0; w < WORD_COUNT; w++) begin
            frame_used[w] = '0;
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        wait_results_drained();
        test_backpressure();
        wait_results_drained();
        test_random_mix(700, 60);
        wait_results_drained();
        test_random_mix(1000, 50);

        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (150) @(posedge aclk);
        if (expected_results.size() != 0) begin
            note_mismatch("results never received", expected_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("frame_bitmap_allocator_tb: clean");
        end else begin
            $display("frame_bitmap_allocator_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fba_pkg.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_datapath.sv
hw/rtl/fba_ctrl.sv
hw/rtl/frame_bitmap_allocator.sv
test/frame_bitmap_allocator_tb.sv
